### sv/fvam_pkg.sv
// ----------------------------------------------------------------------------
// fvam_pkg: shared types and helpers for the binary32 add/mul/madd pipeline
// Operation codes, the adder stage payload struct and small rounding helpers.
// ----------------------------------------------------------------------------
package fvam_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_MUL  = 2'd1,
    FUNC_MADD = 2'd2,
    FUNC_MADX = 2'd3
  } func_t;

  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] nan_pick(input logic [31:0] x, input logic [31:0] y);
    return is_nan(x) ? (x | QUIET_BIT) : (y | QUIET_BIT);
  endfunction

  // Shift right with sticky jam of lost bits.
  function automatic logic [31:0] jam_right(input logic [31:0] v, input logic [9:0] amt);
    logic [63:0] w;
    begin
      if (amt == 10'd0) return v;
      if (amt < 10'd31) begin
        w = {v, 32'd0} >> amt;
        return w[63:32] | {31'd0, (w[31:0] != 32'd0)};
      end
      return {31'd0, (v != 32'd0)};
    end
  endfunction

  // Leading zero count of a 32-bit word (32 when zero).
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    begin
      n = 6'd32;
      hit = 1'b0;
      for (int i = 31; i >= 0; i--) begin
        if (!hit && v[i]) begin
          n = 6'(31 - i);
          hit = 1'b1;
        end
      end
      return n;
    end
  endfunction

  // Final rounding and packing; sig leading one at bit 30.
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e_in,
                                              input logic [31:0] sig_in);
    logic [31:0]        sig;
    logic signed [10:0] e;
    logic [6:0]         rbits;
    logic [32:0]        sum;
    logic [31:0]        r;
    begin
      sig = sig_in;
      e = e_in;
      if (e < 0) begin
        sig = jam_right(sig, 10'(-e));
        e = '0;
      end else if (e > 11'sd253 ||
                   (e == 11'sd253 && ({1'b0, sig} + 33'h40) >= 33'h8000_0000)) begin
        return {s, 31'h7F80_0000};
      end
      rbits = sig[6:0];
      sum = ({1'b0, sig} + 33'h40) >> 7;
      r = sum[31:0];
      if (rbits == 7'h40) r[0] = 1'b0;
      if (r == 32'd0) e = '0;
      return {s, 31'd0} + {1'b0, e[7:0], 23'd0} + r;
    end
  endfunction

  // Add front end result: special case or aligned operands.
  typedef struct packed {
    logic        vld;
    logic        last;
    logic        spec;
    logic [31:0] spec_val;
    logic        sa;
    logic        sub;
    logic [7:0]  ea;
    logic [31:0] ma;
    logic [31:0] mb;
  } add_st_t;

endpackage

### sv/fvam_fadd.sv
// ----------------------------------------------------------------------------
// fvam_fadd: pipelined binary32 adder
// Four stages: align, add, normalize, round. One beat in per cycle.
// ----------------------------------------------------------------------------
module fvam_fadd
  import fvam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic        in_last,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  output logic        out_vld,
  output logic        out_last,
  output logic [31:0] out_val
);

  // Stage 1: specials, swap, align
  add_st_t s1, s1_next;

  always_comb begin
    logic [31:0] a, b;
    logic [7:0]  ea, eb;
    logic [31:0] ma, mb;
    s1_next = '0;
    s1_next.vld = in_vld;
    s1_next.last = in_last;
    a = in_a;
    b = in_b;
    if (is_nan(a) || is_nan(b)) begin
      s1_next.spec = 1'b1;
      s1_next.spec_val = nan_pick(a, b);
    end else if (a[30:23] == 8'hFF) begin
      s1_next.spec = 1'b1;
      s1_next.spec_val = (b[30:23] == 8'hFF && a[31] != b[31]) ? QNAN_DEFAULT : a;
    end else if (b[30:23] == 8'hFF) begin
      s1_next.spec = 1'b1;
      s1_next.spec_val = b;
    end
    if (in_b[30:0] > in_a[30:0]) begin
      a = in_b;
      b = in_a;
    end
    ea = a[30:23];
    eb = b[30:23];
    ma = {9'd0, a[22:0]};
    mb = {9'd0, b[22:0]};
    if (ea != 8'd0) ma[23] = 1'b1; else ea = 8'd1;
    if (eb != 8'd0) mb[23] = 1'b1; else eb = 8'd1;
    s1_next.sa = a[31];
    s1_next.sub = a[31] ^ b[31];
    s1_next.ea = ea;
    s1_next.ma = ma << 7;
    s1_next.mb = jam_right(mb << 7, {2'd0, ea - eb});
  end

  always_ff @(posedge clk) begin
    if (rst) s1 <= '0;
    else     s1 <= s1_next;
  end

  // Stage 2: add or subtract magnitudes
  logic        s2_vld, s2_last, s2_spec, s2_sa, s2_sub;
  logic [31:0] s2_spec_val, s2_m;
  logic [7:0]  s2_ea;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1.vld;
    s2_last <= s1.last;
    s2_spec <= s1.spec;
    s2_spec_val <= s1.spec_val;
    s2_sa <= s1.sa;
    s2_sub <= s1.sub;
    s2_ea <= s1.ea;
    s2_m <= s1.sub ? (s1.ma - s1.mb) : (s1.ma + s1.mb);
  end

  // Stage 3: normalize
  logic               s3_vld, s3_last, s3_done, s3_s;
  logic [31:0]        s3_val, s3_m;
  logic signed [10:0] s3_e;

  always_ff @(posedge clk) begin
    logic [5:0]  lz;
    logic [5:0]  sh;
    logic [7:0]  lim;
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
    s3_last <= s2_last;
    s3_s <= s2_sa;
    s3_done <= 1'b0;
    s3_val <= s2_spec_val;
    s3_m <= s2_m;
    s3_e <= 11'(s2_ea) - 11'sd1;
    lz = lzc32(s2_m);
    lim = s2_ea - 8'd1;
    if (s2_spec) begin
      s3_done <= 1'b1;
    end else if (s2_m == 32'd0) begin
      s3_done <= 1'b1;
      s3_val <= s2_sub ? 32'd0 : {s2_sa, 31'd0};
    end else if (s2_m[31]) begin
      s3_m <= jam_right(s2_m, 10'd1);
      s3_e <= 11'(s2_ea);
    end else begin
      sh = lz - 6'd1;
      if ({2'd0, sh} > lim) sh = lim[5:0];
      s3_m <= s2_m << sh;
      s3_e <= 11'(s2_ea) - 11'sd1 - 11'(sh);
    end
  end

  // Stage 4: round and pack
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= s3_vld;
    out_last <= s3_last;
    out_val <= s3_done ? s3_val : round_pack(s3_s, s3_e, s3_m);
  end

endmodule

### sv/fvam_fmul.sv
// ----------------------------------------------------------------------------
// fvam_fmul: pipelined binary32 multiplier
// Four stages: unpack and normalize, multiply, adjust, round. Extra payload
// (operation, operands and addend) rides along for the following adder.
// ----------------------------------------------------------------------------
module fvam_fmul
  import fvam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic        in_last,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  input  logic [31:0] in_c,
  output logic        out_vld,
  output logic        out_last,
  output logic [1:0]  out_func,
  output logic [31:0] out_a,
  output logic [31:0] out_b,
  output logic [31:0] out_c,
  output logic [31:0] out_prod
);

  // Stage 1: specials and subnormal normalization
  logic               s1_vld, s1_last, s1_spec, s1_s;
  logic [1:0]         s1_func;
  logic [31:0]        s1_a, s1_b, s1_c, s1_spec_val;
  logic [23:0]        s1_fa, s1_fb;
  logic signed [10:0] s1_e;

  always_ff @(posedge clk) begin
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] na, nb;
    logic [5:0]  la, lb;
    logic        sz;
    ea = in_a[30:23];
    eb = in_b[30:23];
    fa = in_a[22:0];
    fb = in_b[22:0];
    sz = in_a[31] ^ in_b[31];
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= in_vld;
    s1_last <= in_last;
    s1_func <= in_func;
    s1_a <= in_a;
    s1_b <= in_b;
    s1_c <= in_c;
    s1_s <= sz;
    s1_spec <= 1'b1;
    if (is_nan(in_a) || is_nan(in_b))       s1_spec_val <= nan_pick(in_a, in_b);
    else if (ea == 8'hFF)
      s1_spec_val <= ({eb, fb} == 31'd0) ? QNAN_DEFAULT : {sz, 31'h7F80_0000};
    else if (eb == 8'hFF)
      s1_spec_val <= ({ea, fa} == 31'd0) ? QNAN_DEFAULT : {sz, 31'h7F80_0000};
    else if ({ea, fa} == 31'd0 || {eb, fb} == 31'd0) s1_spec_val <= {sz, 31'd0};
    else begin
      s1_spec <= 1'b0;
      s1_spec_val <= '0;
    end
    la = lzc32({9'd0, fa}) - 6'd8;
    lb = lzc32({9'd0, fb}) - 6'd8;
    if (ea == 8'd0) na = {1'b0, fa} << la; else na = {1'b1, fa};
    if (eb == 8'd0) nb = {1'b0, fb} << lb; else nb = {1'b1, fb};
    if (ea == 8'd0) la = la; else la = 6'd0;
    if (eb == 8'd0) lb = lb; else lb = 6'd0;
    s1_fa <= na | 24'h80_0000;
    s1_fb <= nb | 24'h80_0000;
    s1_e <= ((ea == 8'd0) ? 11'sd1 : 11'(ea)) - 11'(la)
          + ((eb == 8'd0) ? 11'sd1 : 11'(eb)) - 11'(lb) - 11'sd127;
  end

  // Stage 2: 24x24 multiply
  logic               s2_vld, s2_last, s2_spec, s2_s;
  logic [1:0]         s2_func;
  logic [31:0]        s2_a, s2_b, s2_c, s2_spec_val;
  logic [47:0]        s2_p;
  logic signed [10:0] s2_e;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
    s2_last <= s1_last;
    s2_func <= s1_func;
    s2_a <= s1_a;
    s2_b <= s1_b;
    s2_c <= s1_c;
    s2_spec <= s1_spec;
    s2_spec_val <= s1_spec_val;
    s2_s <= s1_s;
    s2_e <= s1_e;
    s2_p <= s1_fa * s1_fb;
  end

  // Stage 3: form sticky significand and adjust exponent
  logic               s3_vld, s3_last, s3_spec, s3_s;
  logic [1:0]         s3_func;
  logic [31:0]        s3_a, s3_b, s3_c, s3_spec_val, s3_m;
  logic signed [10:0] s3_e;

  always_ff @(posedge clk) begin
    logic [31:0] mz;
    // product of (fa<<7)*(fb<<8) is p<<15; top 32 bits are p[47:17]
    mz = {1'b0, s2_p[47:17]} | {31'd0, (s2_p[16:0] != 17'd0)};
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
    s3_last <= s2_last;
    s3_func <= s2_func;
    s3_a <= s2_a;
    s3_b <= s2_b;
    s3_c <= s2_c;
    s3_spec <= s2_spec;
    s3_spec_val <= s2_spec_val;
    s3_s <= s2_s;
    if (!mz[30]) begin
      s3_m <= mz << 1;
      s3_e <= s2_e - 11'sd1;
    end else begin
      s3_m <= mz;
      s3_e <= s2_e;
    end
  end

  // Stage 4: round and pack
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else     out_vld <= s3_vld;
    out_last <= s3_last;
    out_func <= s3_func;
    out_a <= s3_a;
    out_b <= s3_b;
    out_c <= s3_c;
    out_prod <= s3_spec ? s3_spec_val : round_pack(s3_s, s3_e, s3_m);
  end

endmodule

### sv/float_vector_add_mul_madd_top.sv
// ----------------------------------------------------------------------------
// float_vector_add_mul_madd_top: element-wise binary32 add / mul / madd
// Streams one element per cycle through a multiplier and an adder pipeline.
// ----------------------------------------------------------------------------
// A new element is taken on every cycle that start is high (busy is always
// low). Each result passes through the four-stage multiplier and then the
// four-stage adder, with done high for one cycle and last_out carried along;
// a plain multiply rides an equally deep bypass beside the adder, so results
// leave in order. The receiver cannot stall.
// Multiply-add rounds the product, then the sum (not fused).
module float_vector_add_mul_madd_top
  import fvam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [31:0] addend_c,
  input  logic        last_in,
  output logic        done,
  output logic [31:0] result_value,
  output logic        last_out
);

  logic        m_vld, m_last;
  logic [1:0]  m_func;
  logic [31:0] m_a, m_b, m_c, m_prod;
  logic        a_in_vld, a_vld, a_last, m_is_mul;
  logic [31:0] a_x, a_y, a_val;

  assign busy = 1'b0;

  fvam_fmul u_mul (
    .clk(clk), .rst(rst), .in_vld(start), .in_last(last_in), .in_func(func),
    .in_a(operand_a), .in_b(operand_b), .in_c(addend_c),
    .out_vld(m_vld), .out_last(m_last), .out_func(m_func),
    .out_a(m_a), .out_b(m_b), .out_c(m_c), .out_prod(m_prod)
  );

  // Select adder operands; a plain multiply's adder result is discarded and the product is bypassed below
  always_comb begin
    a_x = m_prod;
    a_y = m_c;
    if (func_t'(m_func) == FUNC_ADD) begin
      a_x = m_a;
      a_y = m_b;
    end
  end
  assign a_in_vld = m_vld;

  fvam_fadd u_add (
    .clk(clk), .rst(rst), .in_vld(a_in_vld), .in_last(m_last),
    .in_a(a_x), .in_b(a_y),
    .out_vld(a_vld), .out_last(a_last), .out_val(a_val)
  );

  // Carry the plain product alongside the adder to keep order
  logic [3:0]  byp_mul;
  logic [31:0] byp_val [4];

  always_ff @(posedge clk) begin
    if (rst) byp_mul <= '0;
    else     byp_mul <= {byp_mul[2:0], m_vld && func_t'(m_func) == FUNC_MUL};
    byp_val[0] <= m_prod;
    for (int i = 1; i < 4; i++) byp_val[i] <= byp_val[i-1];
  end
  assign m_is_mul = byp_mul[3];

  assign done = a_vld;
  assign last_out = a_last;
  assign result_value = m_is_mul ? byp_val[3] : a_val;

  // A result beat never appears without a matching earlier start beat
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 8)) else $error("result without matching start");

  // The multiply bypass only marks a beat that is actually leaving
  a_byp: assert property (@(posedge clk) disable iff (rst)
    m_is_mul |-> done) else $error("bypass flag without result");

  // Every start produces a result, barring a reset in between
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##8 (done || $past(rst, 1) || $past(rst, 2) || $past(rst, 3) || $past(rst, 4)
                || $past(rst, 5) || $past(rst, 6) || $past(rst, 7)))
    else $error("start lost in pipeline");

endmodule
